FILE: sv/incremental_unique_topo_order_top_macros.svh
// Assertion macros for the incremental unique topological order block.
// Used by the port-level checker; needs nothing else.
`ifndef INCREMENTAL_UNIQUE_TOPO_ORDER_TOP_MACROS_SVH
`define INCREMENTAL_UNIQUE_TOPO_ORDER_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define IUTO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define IUTO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/iuto_pkg.sv
// Shared constants, status codes and controller/datapath interface structs
// for the incremental unique topological order block. No dependencies.
package iuto_pkg;

  // Graph size
  localparam int MAX_NODES = 26;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NCNT_W    = $clog2(MAX_NODES + 1);
  localparam int IDEG_W    = $clog2(MAX_NODES + 1);

  // Fixed field widths
  localparam int NODE_W = 5;
  localparam int CFG_W  = 5;
  localparam int REL_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(26);

  // Result status codes
  localparam logic [STAT_W-1:0] ST_UNDET = 2'd0;
  localparam logic [STAT_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_CYCLE = 2'd2;

  // Input kind codes
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic update;
    logic step;
    logic load_fail;
    logic load_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind_clear;
    logic ready_none;
    logic ready_multi;
    logic round_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/iuto_ctrl.sv
// Controller state machine: sequences capture, graph update, ordering rounds
// and result emission. Depends on iuto_pkg.
module iuto_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iuto_pkg::sts_t sts,
  output iuto_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_ROUND  = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Take an item only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (sts.kind_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        if (sts.ready_none || sts.ready_multi) begin
          if (sts.out_free) begin
            cmd.load_fail = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
          if (sts.round_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/iuto_dp.sv
// Datapath: graph store, in-degrees, ordering round logic, order buffer and
// output register. Depends on iuto_pkg; driven by iuto_ctrl commands.
module iuto_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_kind,
  input  logic [iuto_pkg::NODE_W-1:0]   in_from_node,
  input  logic [iuto_pkg::NODE_W-1:0]   in_to_node,
  input  logic                          cfg_valid,
  input  logic [iuto_pkg::CFG_W-1:0]    cfg_node_count,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [iuto_pkg::STAT_W-1:0]   out_status,
  output logic [iuto_pkg::REL_W-1:0]    out_relation_count,
  output logic [iuto_pkg::NODE_W-1:0]   out_position,
  output logic [iuto_pkg::NODE_W-1:0]   out_node,
  output logic                          out_last,
  input  iuto_pkg::cmd_t                cmd,
  output iuto_pkg::sts_t                sts
);

  localparam int N      = iuto_pkg::MAX_NODES;
  localparam int IDX_W  = iuto_pkg::IDX_W;
  localparam int NCNT_W = iuto_pkg::NCNT_W;
  localparam int IDEG_W = iuto_pkg::IDEG_W;
  localparam int NODE_W = iuto_pkg::NODE_W;
  localparam int REL_W  = iuto_pkg::REL_W;
  localparam int STAT_W = iuto_pkg::STAT_W;

  // Captured item and configuration
  logic                         kind_r;
  logic [NODE_W-1:0]            from_r;
  logic [NODE_W-1:0]            to_r;
  logic [iuto_pkg::CFG_W-1:0]   node_count_r;

  // Graph state
  logic [N-1:0]                 adj_r [N];
  logic [IDEG_W-1:0]            indeg_r [N];
  logic [REL_W-1:0]             rel_r;

  // Ordering state
  logic [IDEG_W-1:0]            rem_r [N];
  logic [N-1:0]                 placed_r;
  logic [IDX_W-1:0]             round_r;
  logic [IDX_W-1:0]             emit_r;
  logic [IDX_W-1:0]             order_r [N];

  // Output register
  logic                         out_valid_r;
  logic [STAT_W-1:0]            out_status_r;
  logic [REL_W-1:0]             out_rel_r;
  logic [NODE_W-1:0]            out_pos_r;
  logic [NODE_W-1:0]            out_node_r;
  logic                         out_last_r;

  logic [NCNT_W-1:0]            n_act;
  logic [N-1:0]                 active;
  logic [N-1:0]                 ready;
  logic [IDX_W-1:0]             pick_idx;
  logic [IDX_W-1:0]             rd_addr;
  logic [N-1:0]                 row;
  logic                         in_range;
  logic [IDX_W-1:0]             from_idx;
  logic [IDX_W-1:0]             to_idx;
  logic                         new_edge;
  logic                         out_free;

  // Clamp node count to one .. MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      n_act = NCNT_W'(1);
    end else if (32'(node_count_r) > N) begin
      n_act = NCNT_W'(N);
    end else begin
      n_act = NCNT_W'(node_count_r);
    end
  end

  // Ready scan: active, unplaced, no remaining predecessors
  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < N; j++) begin
      active[j] = (NCNT_W'(j) < n_act);
      ready[j]  = active[j] && !placed_r[j] && (rem_r[j] == '0);
      if (ready[j]) begin
        pick_idx = pick_idx | IDX_W'(j);
      end
    end
  end

  // Single adjacency read port shared by update and round
  assign from_idx = from_r[IDX_W-1:0];
  assign to_idx   = to_r[IDX_W-1:0];
  assign in_range = (32'(from_r) < N) && (32'(to_r) < N);
  assign rd_addr  = cmd.update ? from_idx : pick_idx;
  assign row      = adj_r[rd_addr];
  assign new_edge = in_range && !row[to_idx];

  assign out_free = !out_valid_r || !out_stall;

  // Status to controller
  assign sts.kind_clear  = (kind_r == iuto_pkg::KIND_CLEAR);
  assign sts.ready_none  = (ready == '0);
  assign sts.ready_multi = |(ready & (ready - N'(1)));
  assign sts.round_last  = (NCNT_W'(round_r) == n_act - NCNT_W'(1));
  assign sts.emit_last   = (NCNT_W'(emit_r) == n_act - NCNT_W'(1));
  assign sts.out_free    = out_free;

  // Capture item, hold configuration
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      from_r <= in_from_node;
      to_r   <= in_to_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= iuto_pkg::NODE_COUNT_RST;
    end else if (cfg_valid) begin
      node_count_r <= cfg_node_count;
    end
  end

  // Graph store: clear, add relation, count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int j = 0; j < N; j++) begin
        adj_r[j]   <= '0;
        indeg_r[j] <= '0;
      end
      rel_r <= '0;
    end else if (cmd.update) begin
      if (new_edge) begin
        adj_r[from_idx][to_idx] <= 1'b1;
        indeg_r[to_idx]         <= indeg_r[to_idx] + IDEG_W'(1);
      end
      if (rel_r != '1) begin
        rel_r <= rel_r + REL_W'(1);
      end
    end
  end

  // Ordering rounds: load in-degrees, place the single ready node, relax
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int j = 0; j < N; j++) begin
        rem_r[j] <= indeg_r[j] + IDEG_W'(new_edge && (to_idx == IDX_W'(j)));
      end
      placed_r <= '0;
      round_r  <= '0;
      emit_r   <= '0;
    end else if (cmd.step) begin
      for (int j = 0; j < N; j++) begin
        if (row[j] && (rem_r[j] != '0)) begin
          rem_r[j] <= rem_r[j] - IDEG_W'(1);
        end
      end
      placed_r          <= placed_r | ready;
      order_r[round_r]  <= pick_idx;
      round_r           <= round_r + IDX_W'(1);
    end else if (cmd.load_emit) begin
      emit_r <= emit_r + IDX_W'(1);
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_fail || cmd.load_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fail) begin
      out_status_r <= sts.ready_multi ? iuto_pkg::ST_UNDET : iuto_pkg::ST_CYCLE;
      out_rel_r    <= rel_r;
      out_pos_r    <= '0;
      out_node_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_emit) begin
      out_status_r <= iuto_pkg::ST_FOUND;
      out_rel_r    <= rel_r;
      out_pos_r    <= NODE_W'(emit_r);
      out_node_r   <= NODE_W'(order_r[emit_r]);
      out_last_r   <= sts.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_relation_count = out_rel_r;
  assign out_position       = out_pos_r;
  assign out_node           = out_node_r;
  assign out_last           = out_last_r;

endmodule

FILE: sv/incremental_unique_topo_order_top.sv
// An add transaction runs an update step, then ordering rounds that place one
// node per cycle (up to n, n = active node count), then emits n results, one
// per cycle while out_stall is low; first result is registered. A failed check
// gives one result instead. No new item is taken until the transaction ends.
// A clear transaction captures, then clears. Synchronous active-low reset empties
// the graph and counter at once and sets the node count to 26; no clearing pass.
module incremental_unique_topo_order_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [iuto_pkg::NODE_W-1:0]   in_from_node,
  input  logic [iuto_pkg::NODE_W-1:0]   in_to_node,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [iuto_pkg::CFG_W-1:0]    cfg_node_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iuto_pkg::STAT_W-1:0]   out_status,
  output logic [iuto_pkg::REL_W-1:0]    out_relation_count,
  output logic [iuto_pkg::NODE_W-1:0]   out_position,
  output logic [iuto_pkg::NODE_W-1:0]   out_node,
  output logic                          out_last
);

  iuto_pkg::cmd_t cmd;
  iuto_pkg::sts_t sts;

  // Configuration writes are always accepted and registered
  assign cfg_ready = 1'b1;

  iuto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iuto_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_from_node       (in_from_node),
    .in_to_node         (in_to_node),
    .cfg_valid          (cfg_valid),
    .cfg_node_count     (cfg_node_count),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_relation_count (out_relation_count),
    .out_position       (out_position),
    .out_node           (out_node),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

FILE: sv/iuto_checker.sv
// Port-level checker for the incremental unique topological order block,
// bound to the top level. Depends on iuto_pkg and the macros header.
`include "incremental_unique_topo_order_top_macros.svh"

module iuto_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [iuto_pkg::STAT_W-1:0]   out_status,
  input logic [iuto_pkg::REL_W-1:0]    out_relation_count,
  input logic [iuto_pkg::NODE_W-1:0]   out_position,
  input logic [iuto_pkg::NODE_W-1:0]   out_node,
  input logic                          out_last
);

  // Stalled result holds
  `IUTO_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_relation_count) && $stable(out_position) && $stable(out_node) && $stable(out_last), "stalled result changed")

  // A failed check is a single result with empty position and node
  `IUTO_ASSERT_IMP(a_fail_single, clk, rst_n, out_valid && (out_status != iuto_pkg::ST_FOUND), out_last && (out_position == '0) && (out_node == '0), "failed check result malformed")

  // Status codes stay in range
  `IUTO_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, (out_status == iuto_pkg::ST_UNDET) || (out_status == iuto_pkg::ST_FOUND) || (out_status == iuto_pkg::ST_CYCLE), "bad status code")

  // An accepted transaction blocks the input the next cycle
  `IUTO_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled while busy")

  // Positions advance by one within a run
  `IUTO_ASSERT_NXT(a_pos_advance, clk, rst_n, out_valid && !out_stall && (out_status == iuto_pkg::ST_FOUND) && !out_last, !out_valid || ((out_status == iuto_pkg::ST_FOUND) && (out_position == $past(out_position) + iuto_pkg::NODE_W'(1))), "order position skipped")

endmodule

bind incremental_unique_topo_order_top iuto_checker u_iuto_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_relation_count (out_relation_count),
  .out_position       (out_position),
  .out_node           (out_node),
  .out_last           (out_last)
);
